/* rtl/sicr_pkg.sv */
// Shared types, constants and lookup functions for the radix character converter.
package sicr_pkg;

  // Widths fixed by the interface.
  localparam int VALUE_BITS  = 32;
  localparam int MAX_SYMBOLS = 16;
  localparam int DIGIT_DEPTH = 32;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_AW    = 5;
  localparam int COUNT_W     = 6;
  localparam int RADIX_W     = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HI = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [RADIX_W-1:0]    RADIX_RESET      = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LO_RESET = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HI_RESET = 64'h0000000000003938;

  // One classified value waiting for conversion.
  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } q_item_t;

  // Divider request and response.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] m;
  } div_req_t;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] q;
    logic [DIGIT_W-1:0]    rem;
  } div_rsp_t;

  // Symbol byte for one digit from the two table registers.
  function automatic logic [7:0] symbol_at(input logic [CFG_DATA_W-1:0] lo,
                                           input logic [CFG_DATA_W-1:0] hi,
                                           input logic [DIGIT_W-1:0]    d);
    logic [CFG_DATA_W-1:0] w;
    w = d[3] ? hi : lo;
    return w[{d[2:0], 3'b000} +: 8];
  endfunction

  // floor(2^32 / r) for the legal radix values; zero elsewhere.
  function automatic logic [VALUE_BITS-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [VALUE_BITS-1:0] v;
    case (r)
      5'd2:    v = 32'h8000_0000;
      5'd3:    v = 32'h5555_5555;
      5'd4:    v = 32'h4000_0000;
      5'd5:    v = 32'h3333_3333;
      5'd6:    v = 32'h2AAA_AAAA;
      5'd7:    v = 32'h2492_4924;
      5'd8:    v = 32'h2000_0000;
      5'd9:    v = 32'h1C71_C71C;
      5'd10:   v = 32'h1999_9999;
      5'd11:   v = 32'h1745_D174;
      5'd12:   v = 32'h1555_5555;
      5'd13:   v = 32'h13B1_3B13;
      5'd14:   v = 32'h1249_2492;
      5'd15:   v = 32'h1111_1111;
      5'd16:   v = 32'h1000_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/signed_integer_to_custom_radix_chars_core.sv */
// Top level of the signed integer to radix character stream converter.
//
// Each accepted 32-bit signed value becomes a stream of character bytes, most
// significant digit first, with a leading '-' for negative values and the last
// byte flagged. Digits use the configured radix (2 to 16) and symbol table; if
// the table is invalid the value is accepted and produces nothing. The engine
// handles one value at a time: it takes the value from the queue, produces each
// digit on the reciprocal divider (an issue state, then the divider pipeline),
// then emits the sign for a negative value and plays the digits back through the
// registered digit store read, holding while the output is stalled. A two-entry
// queue lets the input side keep accepting while the engine works or the output
// is stalled.
module signed_integer_to_custom_radix_chars_core
  import sicr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic [VALUE_BITS-1:0]  in_value,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic [7:0]             out_char_out,
  output logic                   out_last_char,
  input  logic                   out_stall
);

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] symbols_lo_r;
  logic [CFG_DATA_W-1:0] symbols_hi_r;
  logic                  q_full;
  logic                  q_push;
  q_item_t               q_in;
  logic                  q_valid;
  logic                  q_pop;
  q_item_t               q_out;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RESET;
      symbols_lo_r <= SYMBOLS_LO_RESET;
      symbols_hi_r <= SYMBOLS_HI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:      radix_r      <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LO: symbols_lo_r <= cfg_data;
        CFG_SYMBOLS_HI: symbols_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sicr_front u_front (
    .in_valid   (in_valid),
    .in_value   (in_value),
    .in_stall   (in_stall),
    .radix      (radix_r),
    .symbols_lo (symbols_lo_r),
    .symbols_hi (symbols_hi_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  sicr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_out)
  );

  sicr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .radix (radix_r),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sicr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .symbols_lo    (symbols_lo_r),
    .symbols_hi    (symbols_hi_r),
    .q_valid       (q_valid),
    .q_item        (q_out),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char),
    .out_stall     (out_stall)
  );

  // A divide request lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_req.valid |=> !div_req.valid)
    else $error("divider request held longer than one cycle");

  // Every divider response answers an earlier request, registered through the divider pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.valid |-> $past(div_req.valid, 2))
    else $error("divider response without a matching request");

  // The engine never issues a new division while a response is landing.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_req.valid |-> !div_rsp.valid)
    else $error("divider request overlaps a response");

endmodule

/* rtl/sicr_front.sv */
// Front end: accepts values, checks the symbol table and forms the sign and magnitude.
module sicr_front
  import sicr_pkg::*;
(
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  in_stall,
  input  logic [RADIX_W-1:0]    radix,
  input  logic [CFG_DATA_W-1:0] symbols_lo,
  input  logic [CFG_DATA_W-1:0] symbols_hi,
  input  logic                  q_full,
  output logic                  q_push,
  output q_item_t               q_item
);

  logic table_ok;

  // The table is good when the radix is in range and every symbol in use is
  // nonzero, neither '-' nor '+', and unique.
  always_comb begin
    logic [7:0] si;
    table_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      si = symbol_at(symbols_lo, symbols_hi, DIGIT_W'(i));
      if (RADIX_W'(i) < radix) begin
        if (si == 8'h00 || si == CHAR_MINUS || si == CHAR_PLUS) begin
          table_ok = 1'b0;
        end
      end
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if (RADIX_W'(j) < radix &&
            symbol_at(symbols_lo, symbols_hi, DIGIT_W'(j)) == si) begin
          table_ok = 1'b0;
        end
      end
    end
  end

  // A transaction is taken whenever the queue has room; values that meet a
  // bad table are dropped without output.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && table_ok;

  // Magnitude of the most negative value still fits in the unsigned word.
  assign q_item.neg = in_value[VALUE_BITS-1];
  assign q_item.mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;

endmodule

/* rtl/sicr_fifo.sv */
// Two-entry queue between the front end and the conversion engine.
module sicr_fifo
  import sicr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/sicr_div.sv */
// Two-stage divider by the radix using a reciprocal multiply and one correction.
module sicr_div
  import sicr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RADIX_W-1:0] radix,
  input  div_req_t           req,
  output div_rsp_t           rsp
);

  logic                    s1_valid_r;
  logic [VALUE_BITS-1:0]   s1_m_r;
  logic [VALUE_BITS-1:0]   s1_qest_r;
  logic [2*VALUE_BITS-1:0] prod;
  logic [VALUE_BITS+RADIX_W-1:0] qr;
  logic [VALUE_BITS-1:0]   rem_full;
  logic                    fix;
  logic                    rsp_valid_r;
  logic [VALUE_BITS-1:0]   q_r;
  logic [DIGIT_W-1:0]      rem_r;

  // Stage one: the estimate is at most one below the true quotient.
  assign prod = req.m * recip(radix);

  // Stage two: remainder from the estimate, then a single step up if needed.
  assign qr       = s1_qest_r * {{VALUE_BITS{1'b0}}, radix};
  assign rem_full = s1_m_r - qr[VALUE_BITS-1:0];
  assign fix      = (rem_full >= {{(VALUE_BITS-RADIX_W){1'b0}}, radix});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= req.valid;
      rsp_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_m_r    <= req.m;
    s1_qest_r <= prod[2*VALUE_BITS-1:VALUE_BITS];
    if (fix) begin
      q_r   <= s1_qest_r + VALUE_BITS'(1);
      rem_r <= DIGIT_W'(rem_full - {{(VALUE_BITS-RADIX_W){1'b0}}, radix});
    end else begin
      q_r   <= s1_qest_r;
      rem_r <= DIGIT_W'(rem_full);
    end
  end

  assign rsp.valid = rsp_valid_r;
  assign rsp.q     = q_r;
  assign rsp.rem   = rem_r;

endmodule

/* rtl/sicr_back.sv */
// Conversion engine: repeated division into the digit store, then playback as characters.
module sicr_back
  import sicr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CFG_DATA_W-1:0] symbols_lo,
  input  logic [CFG_DATA_W-1:0] symbols_hi,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  output logic                  out_valid,
  output logic [7:0]            out_char_out,
  output logic                  out_last_char,
  input  logic                  out_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [COUNT_W-1:0]    cnt_r;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;
  logic [DIGIT_W-1:0]    digit_store [DIGIT_DEPTH];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic                  out_free;
  logic                  st_we;
  logic [COUNT_W-1:0]    cnt_dec;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign st_we    = (state_r == ST_WAIT) && div_rsp.valid;
  assign cnt_dec  = cnt_r - COUNT_W'(1);

  assign div_req.valid = (state_r == ST_ISSUE);
  assign div_req.m     = mag_r;

  // Digit store, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (st_we) begin
      digit_store[cnt_r[DIGIT_AW-1:0]] <= div_rsp.rem;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= digit_store[cnt_dec[DIGIT_AW-1:0]];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            mag_r   <= q_item.mag;
            neg_r   <= q_item.neg;
            cnt_r   <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_rsp.valid) begin
            cnt_r <= cnt_r + COUNT_W'(1);
            mag_r <= div_rsp.q;
            if (div_rsp.q == '0 || cnt_r == COUNT_W'(DIGIT_DEPTH - 1)) begin
              state_r <= neg_r ? ST_SIGN : ST_READ;
            end else begin
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= symbol_at(symbols_lo, symbols_hi, rd_data_r);
            out_last_r  <= (cnt_r == COUNT_W'(1));
            cnt_r       <= cnt_dec;
            state_r     <= (cnt_r == COUNT_W'(1)) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

endmodule
